FILE: sv/apla_pkg.sv
// apla_pkg: shared widths, constants, coefficient table and control word types
// for the airflow polynomial linearizer; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package apla_pkg;

    // samples per average, 1 to 64
    localparam int SAMPLE_COUNT = 10;

    localparam int ADC_W     = 10;
    localparam int FLOW_W    = 16;
    localparam int VOLT_W    = 23;   // unsigned q3.20
    localparam int FRAC_BITS = 20;
    localparam int OUT_SHIFT = 8;    // q20.20 down to q4.12
    localparam int ACC_W     = 40;   // horner accumulator, signed
    localparam int COEF_W    = 28;   // signed q8.20 coefficients
    localparam int OP_W      = 24;   // multiplier operand, signed
    localparam int PROD_W    = 48;
    localparam int SUM_W     = 22;
    localparam int CNT_W     = 7;
    localparam int K_W       = 3;
    localparam int M_W       = 13;   // raw * 5
    localparam int DQ_W      = 3;

    // volts = raw * VOLT_NUM * 2^20 / VOLT_DEN
    localparam int VOLT_NUM = 5;
    localparam int VOLT_DEN = 1023;

    localparam logic [K_W-1:0] LAST_K = K_W'(6);

    // exact divide of the sum by SAMPLE_COUNT as multiply by rounded-up reciprocal
    localparam int DIV_L     = $clog2(SAMPLE_COUNT);
    localparam int DIV_SHIFT = SUM_W + DIV_L;
    localparam longint unsigned DIV_RECIP =
        ((64'd1 << DIV_SHIFT) + 64'(SAMPLE_COUNT) - 64'd1) / 64'(SAMPLE_COUNT);

    typedef enum logic [1:0] {
        ASEL_LO,
        ASEL_HI,
        ASEL_SUM
    } t_asel;

    typedef enum logic {
        BSEL_VOLTS,
        BSEL_RECIP
    } t_bsel;

    typedef enum logic [2:0] {
        SQ_NEXT,
        SQ_LOOP,          // back to target until the last coefficient
        SQ_DONE_IF_OPEN,  // finish unless the window is full
        SQ_WAIT_DONE,     // finish once the result register is free
        SQ_DONE
    } t_seq;

    typedef enum logic [2:0] {
        ST_MUL_LO,
        ST_MUL_HI,
        ST_ADD,
        ST_FLOW,
        ST_CHECK,
        ST_DIV,
        ST_EMIT
    } t_step;

    typedef struct packed {
        t_asel a_sel;
        t_bsel b_sel;
        logic  mul_en;
        logic  part_en;
        logic  horner_en;
        logic  k_inc;
        logic  flow_add;
        logic  emit;
        t_seq  seq;
        t_step target;
    } t_ctl;

    typedef struct packed {
        logic k_last;
        logic window_full;
        logic out_blocked;
    } t_stat;

    localparam t_ctl CTL_NOP = '{
        a_sel: ASEL_LO, b_sel: BSEL_VOLTS, mul_en: 1'b0, part_en: 1'b0,
        horner_en: 1'b0, k_inc: 1'b0, flow_add: 1'b0, emit: 1'b0,
        seq: SQ_DONE, target: ST_MUL_LO
    };

    // horner coefficients, highest power first
    function automatic logic signed [COEF_W-1:0] apla_coef(input logic [K_W-1:0] k);
        logic signed [COEF_W-1:0] c;
        unique case (k)
            3'd0:    c = -28'sd2752869;
            3'd1:    c =  28'sd21885270;
            3'd2:    c = -28'sd71460140;
            3'd3:    c =  28'sd122853031;
            3'd4:    c = -28'sd117395696;
            3'd5:    c =  28'sd60852934;
            3'd6:    c = -28'sd12583206;
            default: c = '0;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

FILE: sv/apla_sample_if.sv
// apla_sample_if: valid/ready channel carrying one raw converter sample
// depends on apla_pkg
`timescale 1ns / 1ps
`default_nettype none

interface apla_sample_if;
    logic                        valid;
    logic                        ready;
    logic [apla_pkg::ADC_W-1:0]  adc_sample;

    modport source (output valid, output adc_sample, input ready);
    modport sink   (input valid, input adc_sample, output ready);
endinterface

`default_nettype wire

FILE: sv/apla_flow_if.sv
// apla_flow_if: valid/ready channel carrying one averaged flow value
// depends on apla_pkg
`timescale 1ns / 1ps
`default_nettype none

interface apla_flow_if;
    logic                         valid;
    logic                         ready;
    logic [apla_pkg::FLOW_W-1:0]  mean_flow;

    modport source (output valid, output mean_flow, input ready);
    modport sink   (input valid, input mean_flow, output ready);
endinterface

`default_nettype wire

FILE: sv/apla_sequencer.sv
// apla_sequencer: step counter and microcode rom driving the datapath
// depends on apla_pkg
`timescale 1ns / 1ps
`default_nettype none

module apla_sequencer (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  apla_pkg::t_stat  i_stat,
    output apla_pkg::t_ctl   o_ctl,
    output logic             o_idle
);
    import apla_pkg::*;

    typedef enum logic {
        SEQ_IDLE,
        SEQ_RUN
    } t_state;

    t_state r_state;
    t_step  r_step;
    t_ctl   w_word;

    function automatic t_ctl ucode(input t_step s);
        t_ctl w;
        w = CTL_NOP;
        unique case (s)
            ST_MUL_LO: begin
                w.a_sel  = ASEL_LO;
                w.b_sel  = BSEL_VOLTS;
                w.mul_en = 1'b1;
                w.seq    = SQ_NEXT;
            end
            ST_MUL_HI: begin
                w.part_en = 1'b1;
                w.a_sel   = ASEL_HI;
                w.b_sel   = BSEL_VOLTS;
                w.mul_en  = 1'b1;
                w.seq     = SQ_NEXT;
            end
            ST_ADD: begin
                w.horner_en = 1'b1;
                w.k_inc     = 1'b1;
                w.seq       = SQ_LOOP;
                w.target    = ST_MUL_LO;
            end
            ST_FLOW: begin
                w.flow_add = 1'b1;
                w.seq      = SQ_NEXT;
            end
            ST_CHECK: begin
                w.seq = SQ_DONE_IF_OPEN;
            end
            ST_DIV: begin
                w.a_sel  = ASEL_SUM;
                w.b_sel  = BSEL_RECIP;
                w.mul_en = 1'b1;
                w.seq    = SQ_NEXT;
            end
            ST_EMIT: begin
                w.emit = 1'b1;
                w.seq  = SQ_WAIT_DONE;
            end
            default: w = CTL_NOP;
        endcase
        return w;
    endfunction

    assign w_word = ucode(r_step);
    assign o_ctl  = (r_state == SEQ_RUN) ? w_word : CTL_NOP;
    assign o_idle = (r_state == SEQ_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SEQ_IDLE;
            r_step  <= ST_MUL_LO;
        end else begin
            unique case (r_state)
                SEQ_IDLE: begin
                    if (i_start) begin
                        r_state <= SEQ_RUN;
                        r_step  <= ST_MUL_LO;
                    end
                end
                SEQ_RUN: begin
                    unique case (w_word.seq)
                        SQ_NEXT: r_step <= t_step'(r_step + 3'd1);
                        SQ_LOOP: begin
                            if (!i_stat.k_last) begin
                                r_step <= w_word.target;
                            end else begin
                                r_step <= t_step'(r_step + 3'd1);
                            end
                        end
                        SQ_DONE_IF_OPEN: begin
                            if (!i_stat.window_full) begin
                                r_state <= SEQ_IDLE;
                            end else begin
                                r_step <= t_step'(r_step + 3'd1);
                            end
                        end
                        SQ_WAIT_DONE: begin
                            if (!i_stat.out_blocked) begin
                                r_state <= SEQ_IDLE;
                            end
                        end
                        default: r_state <= SEQ_IDLE;
                    endcase
                end
                default: r_state <= SEQ_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: sv/apla_datapath.sv
// apla_datapath: volts scaling, shared multiplier, horner accumulator,
// flow clamp, window sum and result register; depends on apla_pkg
`timescale 1ns / 1ps
`default_nettype none

module apla_datapath (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [apla_pkg::ADC_W-1:0]   i_adc_sample,
    input  apla_pkg::t_ctl               i_ctl,
    input  logic                         i_out_ready,
    output logic                         o_out_valid,
    output logic [apla_pkg::FLOW_W-1:0]  o_mean_flow,
    output apla_pkg::t_stat              o_stat
);
    import apla_pkg::*;

    logic [M_W-1:0]              w_m;
    logic [DQ_W-1:0]             w_dq;
    logic [VOLT_W-1:0]           w_volts;
    logic signed [OP_W-1:0]      w_a;
    logic signed [OP_W-1:0]      w_b;
    logic signed [PROD_W-1:0]    w_mul;
    logic [FLOW_W-1:0]           w_flow;
    logic                        w_blocked;
    logic                        w_emit;

    logic [VOLT_W-1:0]           r_volts;
    logic signed [ACC_W-1:0]     r_acc;
    logic signed [ACC_W-1:0]     r_part;
    logic signed [PROD_W-1:0]    r_prod;
    logic [FLOW_W-1:0]           r_mean;
    logic [K_W-1:0]              r_k;
    logic [SUM_W-1:0]            r_sum;
    logic [CNT_W-1:0]            r_count;
    logic                        r_out_valid;

    // raw*5*2^20/1023 = m*1025 + floor(m/1023), m = raw*5 <= 5*1023
    assign w_m = M_W'({i_adc_sample, 2'b00}) + M_W'(i_adc_sample);

    always_comb begin
        w_dq = '0;
        for (int j = 1; j <= VOLT_NUM; j++) begin
            if (w_m >= M_W'(j * VOLT_DEN)) begin
                w_dq = w_dq + DQ_W'(1);
            end
        end
    end

    assign w_volts = VOLT_W'({w_m, 10'b0}) + VOLT_W'(w_m) + VOLT_W'(w_dq);

    // operand select for the one shared multiplier
    always_comb begin
        unique case (i_ctl.a_sel)
            ASEL_LO:  w_a = OP_W'({1'b0, r_acc[FRAC_BITS-1:0]});
            ASEL_HI:  w_a = OP_W'($signed(r_acc[ACC_W-1:FRAC_BITS]));
            ASEL_SUM: w_a = OP_W'({1'b0, r_sum});
            default:  w_a = '0;
        endcase
        unique case (i_ctl.b_sel)
            BSEL_VOLTS: w_b = OP_W'({1'b0, r_volts});
            BSEL_RECIP: w_b = OP_W'(DIV_RECIP);
            default:    w_b = '0;
        endcase
    end

    assign w_mul = PROD_W'(w_a) * PROD_W'(w_b);

    // clamp at zero, drop 8 fraction bits, saturate
    always_comb begin
        if (r_acc[ACC_W-1] || (r_acc == '0)) begin
            w_flow = '0;
        end else if (|r_acc[ACC_W-1:FLOW_W+OUT_SHIFT]) begin
            w_flow = '1;
        end else begin
            w_flow = r_acc[OUT_SHIFT +: FLOW_W];
        end
    end

    assign w_blocked = r_out_valid && !i_out_ready;
    assign w_emit    = i_ctl.emit && !w_blocked;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k         <= '0;
            r_sum       <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_start) begin
                r_k <= K_W'(1);
            end else if (i_ctl.k_inc) begin
                r_k <= r_k + K_W'(1);
            end
            if (w_emit) begin
                r_sum   <= '0;
                r_count <= '0;
            end else if (i_ctl.flow_add) begin
                r_sum   <= r_sum + SUM_W'(w_flow);
                r_count <= r_count + CNT_W'(1);
            end
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_volts <= w_volts;
            r_acc   <= ACC_W'(apla_coef('0));
        end else if (i_ctl.horner_en) begin
            r_acc <= r_prod[ACC_W-1:0] + r_part;
        end
        if (i_ctl.mul_en) begin
            r_prod <= w_mul;
        end
        // low partial product is never negative, so floor is a plain shift
        if (i_ctl.part_en) begin
            r_part <= $signed(ACC_W'({1'b0, r_prod[PROD_W-2:FRAC_BITS]}))
                      + ACC_W'(apla_coef(r_k));
        end
        if (w_emit) begin
            r_mean <= r_prod[DIV_SHIFT +: FLOW_W];
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_mean_flow        = r_mean;
    assign o_stat.k_last      = (r_k == LAST_K);
    assign o_stat.window_full = (r_count == CNT_W'(SAMPLE_COUNT));
    assign o_stat.out_blocked = w_blocked;

endmodule

`default_nettype wire

FILE: sv/airflow_poly_linearize_average.sv
// airflow_poly_linearize_average: top level of the airflow linearizer
// depends on apla_pkg, apla_sample_if, apla_flow_if, apla_sequencer, apla_datapath
`timescale 1ns / 1ps
`default_nettype none

// Each raw 10-bit sample beat on i_sample is scaled to volts (unsigned q3.20),
// run through a sixth-order polynomial by horner's rule, clamped at zero and
// saturated to unsigned q4.12 m/s, then summed. After every SAMPLE_COUNT
// samples (apla_pkg) one beat on o_flow carries the truncated mean and the sum
// restarts. Samples are taken one at a time: i_sample.ready is high only while
// the sequencer is idle. A sample that closes a window also waits, before the
// next accept, while the previous result still sits unclaimed in the output
// register. The work per sample is set by the single 24x24 multiplier: each of
// the six horner steps is two partial products (low and high halves of the
// accumulator) and one add, three microcode steps, and the window mean takes
// one more pass through the same multiplier (multiply by reciprocal). A
// finished mean waits in its own register, so the next sample is accepted
// while o_flow is stalled.
module airflow_poly_linearize_average (
    input  logic          i_clk,
    input  logic          i_rst_n,
    apla_sample_if.sink   i_sample,
    apla_flow_if.source   o_flow
);
    import apla_pkg::*;

    t_ctl  w_ctl;
    t_stat w_stat;
    logic  w_idle;
    logic  w_start;

    // sample beat taken only when the sequencer is idle
    assign i_sample.ready = w_idle;
    assign w_start        = i_sample.valid && i_sample.ready;

    // step counter and microcode rom
    apla_sequencer u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_stat  (w_stat),
        .o_ctl   (w_ctl),
        .o_idle  (w_idle)
    );

    // shared multiplier, horner accumulator, window sum, result register
    apla_datapath u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (w_start),
        .i_adc_sample (i_sample.adc_sample),
        .i_ctl        (w_ctl),
        .i_out_ready  (o_flow.ready),
        .o_out_valid  (o_flow.valid),
        .o_mean_flow  (o_flow.mean_flow),
        .o_stat       (w_stat)
    );

`ifndef SYNTHESIS
    // one sample at a time: an accepted beat starts the sequencer
    a_busy_after_accept: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (i_sample.valid && i_sample.ready) |=> !i_sample.ready
    ) else $error("sample accepted while a previous one is in flight");

    // a result appears only from the emit step
    a_valid_from_emit: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_flow.valid) |-> $past(w_ctl.emit)
    ) else $error("result valid without an emit step");

    // emit only on a full window
    a_emit_full_window: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.emit |-> w_stat.window_full
    ) else $error("emit step reached with an open window");

    // idle sequencer leaves the datapath alone
    a_idle_quiet: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        i_sample.ready |-> (!w_ctl.mul_en && !w_ctl.flow_add && !w_ctl.horner_en)
    ) else $error("datapath control active while idle");
`endif

endmodule

`default_nettype wire
